// ===== rtl/vpra_pkg.sv =====
package vpra_pkg;

   localparam int BUF_BYTES_DEF = 4096;
   localparam int HDR_BYTES_DEF = 8;

   localparam int LEN_W  = 12;
   localparam int OFF_W  = 12;
   localparam int SPAN_W = 13;
   localparam int CSR_W  = 13;

   localparam logic [CSR_W-1:0] CSR_RESET = 13'd4096;
   localparam int ALIGN_ADD = 3;

   typedef enum logic [1:0] {
      OP_RESERVE = 2'd0,
      OP_COMMIT  = 2'd1,
      OP_CONSUME = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_ROOM = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_OVER    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RES_EVAL,
      S_PLACE,
      S_COMMIT_EVAL,
      S_HEAD_STEP,
      S_HEAD_LOAD
   } state_type;

   typedef struct packed {
      opcode_type       opcode;
      logic [LEN_W-1:0] length;
   } req_word_type;

   typedef struct packed {
      status_type       status;
      logic [OFF_W-1:0] alloc_offset;
      logic             head_valid;
      logic [OFF_W-1:0] head_offset;
      logic [LEN_W-1:0] head_length;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic       latch;
      logic       rd_tail;
      logic       rd_head;
      logic       rd_next;
      logic       wr_first;
      logic       wr_pad;
      logic       wr_place;
      logic       place_zero;
      logic       wr_commit;
      logic       drop_all;
      logic       load_head_len;
      logic       respond;
      logic       rsp_alloc;
      status_type rsp_status;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      opcode_type op;
      logic       not_empty;
      logic       head_eq_tail;
      logic       too_big;
      logic       res_fail;
      logic       res_pad;
      logic       commit_over;
   } stat_type;

endpackage

// ===== rtl/vpra_ctrl.sv =====
module vpra_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  vpra_pkg::stat_type stat,
   output vpra_pkg::cmd_type  cmd,
   output logic               busy
);

   vpra_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vpra_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != vpra_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rsp_status = vpra_pkg::ST_OK;
      case (state_ff)
         vpra_pkg::S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in = vpra_pkg::S_DECODE;
            end
         end
         vpra_pkg::S_DECODE: begin
            state_in = vpra_pkg::S_IDLE;
            case (stat.op)
               vpra_pkg::OP_RESERVE: begin
                  if (!stat.not_empty) begin
                     cmd.respond = 1'b1;
                     if (stat.too_big) begin
                        cmd.rsp_status = vpra_pkg::ST_NO_ROOM;
                     end else begin
                        cmd.wr_first = 1'b1;
                        cmd.place_zero = 1'b1;
                        cmd.rsp_alloc = 1'b1;
                     end
                  end else begin
                     cmd.rd_tail = 1'b1;
                     state_in = vpra_pkg::S_RES_EVAL;
                  end
               end
               vpra_pkg::OP_COMMIT: begin
                  if (!stat.not_empty) begin
                     cmd.respond = 1'b1;
                     cmd.rsp_status = vpra_pkg::ST_EMPTY;
                  end else begin
                     cmd.rd_tail = 1'b1;
                     state_in = vpra_pkg::S_COMMIT_EVAL;
                  end
               end
               vpra_pkg::OP_CONSUME: begin
                  if (!stat.not_empty) begin
                     cmd.respond = 1'b1;
                     cmd.rsp_status = vpra_pkg::ST_EMPTY;
                  end else if (stat.head_eq_tail) begin
                     cmd.drop_all = 1'b1;
                     cmd.respond = 1'b1;
                  end else begin
                     cmd.rd_head = 1'b1;
                     state_in = vpra_pkg::S_HEAD_STEP;
                  end
               end
               default: begin
                  cmd.respond = 1'b1;
               end
            endcase
         end
         vpra_pkg::S_RES_EVAL: begin
            if (stat.res_fail) begin
               cmd.respond = 1'b1;
               cmd.rsp_status = vpra_pkg::ST_NO_ROOM;
               state_in = vpra_pkg::S_IDLE;
            end else if (stat.res_pad) begin
               // stretch tail span to the ring end, then place at zero
               cmd.wr_pad = 1'b1;
               state_in = vpra_pkg::S_PLACE;
            end else begin
               cmd.wr_place = 1'b1;
               cmd.respond = 1'b1;
               cmd.rsp_alloc = 1'b1;
               state_in = vpra_pkg::S_IDLE;
            end
         end
         vpra_pkg::S_PLACE: begin
            cmd.wr_place = 1'b1;
            cmd.place_zero = 1'b1;
            cmd.respond = 1'b1;
            cmd.rsp_alloc = 1'b1;
            state_in = vpra_pkg::S_IDLE;
         end
         vpra_pkg::S_COMMIT_EVAL: begin
            cmd.respond = 1'b1;
            if (stat.commit_over) begin
               cmd.rsp_status = vpra_pkg::ST_OVER;
            end else begin
               cmd.wr_commit = 1'b1;
            end
            state_in = vpra_pkg::S_IDLE;
         end
         vpra_pkg::S_HEAD_STEP: begin
            cmd.rd_next = 1'b1;
            state_in = vpra_pkg::S_HEAD_LOAD;
         end
         vpra_pkg::S_HEAD_LOAD: begin
            cmd.load_head_len = 1'b1;
            cmd.respond = 1'b1;
            state_in = vpra_pkg::S_IDLE;
         end
         default: begin
            state_in = vpra_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/vpra_datapath.sv =====
module vpra_datapath #(
   parameter int BUF_BYTES = vpra_pkg::BUF_BYTES_DEF,
   parameter int HDR_BYTES = vpra_pkg::HDR_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  vpra_pkg::req_word_type       req_word,
   input  logic                         csr_we,
   input  logic [vpra_pkg::CSR_W-1:0]   csr_wdata,
   input  vpra_pkg::cmd_type            cmd,
   output vpra_pkg::stat_type           stat,
   output logic                         rsp_strobe,
   output vpra_pkg::rsp_word_type       rsp_word
);

   localparam int POS_W  = $clog2(BUF_BYTES);
   localparam int SIZE_W = $clog2(BUF_BYTES + 1);
   localparam int AW     = POS_W - 2;
   localparam int DEPTH  = BUF_BYTES / 4;
   localparam int SPAN_W = vpra_pkg::SPAN_W;
   localparam int LEN_W  = vpra_pkg::LEN_W;
   localparam int OFF_W  = vpra_pkg::OFF_W;
   localparam int SUM_W  = ((POS_W > SPAN_W) ? POS_W : SPAN_W) + 1;

   typedef struct packed {
      logic [SPAN_W-1:0] span;
      logic [LEN_W-1:0]  len;
   } entry_type;

   function automatic logic [SIZE_W-1:0] clamp_size(logic [vpra_pkg::CSR_W-1:0] v);
      logic [vpra_pkg::CSR_W-1:0] a;
      a = v & ~vpra_pkg::CSR_W'(3);
      if (a < vpra_pkg::CSR_W'(16)) begin
         return SIZE_W'(16);
      end else if (32'(a) > BUF_BYTES) begin
         return SIZE_W'(BUF_BYTES);
      end else begin
         return SIZE_W'(a);
      end
   endfunction

   entry_type store_ff [DEPTH];
   entry_type rdata_ff;

   vpra_pkg::opcode_type   op_ff;
   logic [LEN_W-1:0]       len_ff;
   logic [SPAN_W-1:0]      need_ff, need_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic [POS_W-1:0]       head_ff, head_in;
   logic [POS_W-1:0]       tail_ff, tail_in;
   logic                   not_empty_ff, not_empty_in;
   logic [LEN_W-1:0]       head_len_ff, head_len_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   vpra_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [SUM_W-1:0] size_x, head_x, tail_x, span_x, need_x;
   logic [SUM_W-1:0] sum_t, wpos_x, sum_h, nhead_x;
   logic [POS_W-1:0] wpos, nhead, place_pos;
   logic             wrap_full, head_lt_w, fits_end;
   logic [SPAN_W-1:0] pad_span, commit_span;
   logic [LEN_W-1:0]  shrink;

   logic              mem_we, mem_re;
   logic [AW-1:0]     mem_addr;
   entry_type         mem_wdata;

   // operand decode
   assign need_in = SPAN_W'(32'(req_word.length) + 32'(HDR_BYTES) + vpra_pkg::ALIGN_ADD)
                    & ~SPAN_W'(vpra_pkg::ALIGN_ADD);

   always_comb begin
      size_x = SUM_W'(size_ff);
      head_x = SUM_W'(head_ff);
      tail_x = SUM_W'(tail_ff);
      span_x = SUM_W'(rdata_ff.span);
      need_x = SUM_W'(need_ff);

      // end of tail packet, wrapped
      sum_t  = tail_x + span_x;
      wpos_x = (sum_t >= size_x) ? (sum_t - size_x) : sum_t;
      wpos   = POS_W'(wpos_x);

      // head after dropping the oldest packet
      sum_h   = head_x + span_x;
      nhead_x = (sum_h >= size_x) ? (sum_h - size_x) : sum_h;
      nhead   = POS_W'(nhead_x);

      wrap_full = (wpos_x == head_x);
      head_lt_w = (head_x < wpos_x);
      fits_end  = (need_x <= size_x - wpos_x);

      pad_span    = SPAN_W'(span_x + size_x - wpos_x);
      shrink      = (rdata_ff.len - len_ff) & ~LEN_W'(vpra_pkg::ALIGN_ADD);
      commit_span = rdata_ff.span - SPAN_W'(shrink);

      place_pos = cmd.place_zero ? '0 : wpos;
   end

   always_comb begin
      stat.op           = op_ff;
      stat.not_empty    = not_empty_ff;
      stat.head_eq_tail = (head_ff == tail_ff);
      stat.too_big      = (need_x > size_x);
      stat.res_fail     = wrap_full ||
                          (head_lt_w ? (!fits_end && (need_x >= head_x))
                                     : (need_x > (head_x - wpos_x)));
      stat.res_pad      = !wrap_full && head_lt_w && !fits_end && (need_x < head_x);
      stat.commit_over  = (len_ff > rdata_ff.len);
   end

   // single port to the header store
   always_comb begin
      mem_we    = cmd.wr_first | cmd.wr_pad | cmd.wr_place | cmd.wr_commit;
      mem_re    = cmd.rd_tail | cmd.rd_head | cmd.rd_next;
      mem_addr  = '0;
      mem_wdata = '{span: need_ff, len: len_ff};
      if (cmd.rd_tail || cmd.wr_pad || cmd.wr_commit) begin
         mem_addr = tail_ff[POS_W-1:2];
      end else if (cmd.rd_head) begin
         mem_addr = head_ff[POS_W-1:2];
      end else if (cmd.rd_next) begin
         mem_addr = nhead[POS_W-1:2];
      end else if (cmd.wr_place) begin
         mem_addr = place_pos[POS_W-1:2];
      end
      if (cmd.wr_pad) begin
         mem_wdata = '{span: pad_span, len: rdata_ff.len};
      end else if (cmd.wr_commit) begin
         mem_wdata = '{span: commit_span, len: len_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= store_ff[mem_addr];
      end
   end

   always_comb begin
      size_in      = size_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      not_empty_in = not_empty_ff;
      head_len_in  = head_len_ff;
      if (csr_we) begin
         size_in      = clamp_size(csr_wdata);
         head_in      = '0;
         tail_in      = '0;
         not_empty_in = 1'b0;
      end else begin
         if (cmd.wr_first) begin
            head_in      = '0;
            tail_in      = '0;
            not_empty_in = 1'b1;
            head_len_in  = len_ff;
         end
         if (cmd.wr_place) begin
            tail_in = place_pos;
         end
         if (cmd.wr_commit && (head_ff == tail_ff)) begin
            head_len_in = len_ff;
         end
         if (cmd.drop_all) begin
            head_in      = '0;
            tail_in      = '0;
            not_empty_in = 1'b0;
         end
         if (cmd.rd_next) begin
            head_in = nhead;
         end
         if (cmd.load_head_len) begin
            head_len_in = rdata_ff.len;
         end
      end
   end

   // result reflects the queue after this word
   always_comb begin
      rsp_strobe_in            = cmd.respond;
      rsp_word_in.status       = cmd.rsp_status;
      rsp_word_in.alloc_offset = cmd.rsp_alloc ? OFF_W'(place_pos) : '0;
      rsp_word_in.head_valid   = not_empty_in;
      rsp_word_in.head_offset  = not_empty_in ? OFF_W'(head_in) : '0;
      rsp_word_in.head_length  = not_empty_in ? head_len_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff       <= clamp_size(vpra_pkg::CSR_RESET);
         head_ff       <= '0;
         tail_ff       <= '0;
         not_empty_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         size_ff       <= size_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         not_empty_ff  <= not_empty_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_word.opcode;
         len_ff  <= req_word.length;
         need_ff <= need_in;
      end
      head_len_ff <= head_len_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ===== rtl/variable_packet_ring_allocator.sv =====
// Packet ring allocator: keeps a FIFO of variable-length packets in a
// circular byte buffer and hands out four-byte aligned header offsets.
// Input: drive req_word (opcode, length) with start; the word is taken on
// a clock edge where start is high and busy is low. busy stays high until
// the word is finished, so one word is in flight at a time.
// Result: rsp_word is shown for exactly one cycle with rsp_strobe high. It
// carries the status, the reserved offset and the head packet after the
// word. The receiver cannot stall; it must capture the word on the strobe.
// Words that see an empty queue, opcode 3, or a consume of the last packet
// answer from S_DECODE; a reserve that fails or fits without wrapping from
// S_RES_EVAL, a commit from S_COMMIT_EVAL, a wrapping reserve from S_PLACE
// after S_RES_EVAL, a consume with packets left from S_HEAD_LOAD after
// S_HEAD_STEP. The single-port header store sets this: reads are registered
// and a wrap needs two writes. A new word can be taken in the strobe cycle.
// csr_we/csr_wdata set the ring size (rounded down to four, clamped) and
// empty the queue; write only while busy is low.
// Reset empties the queue and sets the ring size to 4096 bytes, clamped to BUF_BYTES.
module variable_packet_ring_allocator #(
   parameter int BUF_BYTES = vpra_pkg::BUF_BYTES_DEF,
   parameter int HDR_BYTES = vpra_pkg::HDR_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  vpra_pkg::req_word_type     req_word,
   output logic                       rsp_strobe,
   output vpra_pkg::rsp_word_type     rsp_word,
   input  logic                       csr_we,
   input  logic [vpra_pkg::CSR_W-1:0] csr_wdata
);

   vpra_pkg::cmd_type  cmd;
   vpra_pkg::stat_type stat;

   vpra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   vpra_datapath #(
      .BUF_BYTES (BUF_BYTES),
      .HDR_BYTES (HDR_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

// ===== rtl/vpra_checker.sv =====
module vpra_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_strobe,
   input vpra_pkg::rsp_word_type     rsp_word
);

   // busy is high in the cycle after a word is accepted
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // result is delivered as the block goes idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.head_valid) |->
         (rsp_word.head_offset == '0 && rsp_word.head_length == '0))
      else $error("head fields set on empty queue");

   a_fail_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != vpra_pkg::ST_OK) |->
         (rsp_word.alloc_offset == '0))
      else $error("offset reported on failed word");

endmodule

bind variable_packet_ring_allocator vpra_checker u_vpra_checker (.*);
